// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mcst_pkg.sv
// Shared types and constants of the soft timer bank.
`timescale 1ns / 1ps
package mcst_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int ID_W      = 4;
    localparam int PERIOD_W  = 32;
    localparam int RUN_W     = 31;
    localparam int DIV_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_START_ONE  = 2'd1,
        FUNC_START_AUTO = 2'd2,
        FUNC_STOP       = 2'd3
    } t_func;

    typedef enum logic {
        KIND_FIRED   = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIV   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWER_DIV = 1'b1;

    localparam logic [DIV_W-1:0] SLOW_DIV_RST   = 8'd10;
    localparam logic [DIV_W-1:0] SLOWER_DIV_RST = 8'd50;
    localparam logic [RUN_W-1:0] RUN_WRAP       = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic cmd_exec;
        logic walk_start;
        logic walk_step;
        logic sum_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_idx;
        logic fire_due;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/multi_channel_soft_timer_bank.sv
// Top level of the soft timer bank: stream ports, controller and datapath.
//
//  channel   direction  payload
//  s_axis    in         tdata: func, timer_id, period, attach
//  m_axis    out        tdata: fired_id, run_time, pulse_slow, pulse_slower;
//                       tuser: kind; tlast: last
//  cfg       in         write enable, register index, 8-bit data
//
// A start or stop command is executed in the idle state. A tick passes through accept,
// one step per timer through the counter memory read port, and summary, and it holds
// while a fired or summary result finds the result register full.
// The walk holds while a fired result finds the result register full.
// Reset is synchronous; per-timer valid bits stand in for clearing the memories.
`timescale 1ns / 1ps
module multi_channel_soft_timer_bank
    import mcst_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // func, timer_id, period, attach, pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // fired_id, run_time, pulse_slow,
                                                // pulse_slower, pad
    output logic                 m_axis_tuser,  // kind
    output logic                 m_axis_tlast
);

    t_func            in_func;
    logic [ID_W-1:0]  in_id;
    logic [PERIOD_W-1:0] in_period;
    logic             in_attach;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    t_kind            out_kind;
    logic [ID_W-1:0]  out_id;
    logic [RUN_W-1:0] out_run;
    logic             out_ps, out_pss;

    assign in_func   = t_func'(s_axis_tdata[1:0]);
    assign in_id     = s_axis_tdata[5:2];
    assign in_period = s_axis_tdata[37:6];
    assign in_attach = s_axis_tdata[38];

    mcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (in_func),
        .i_sts      (dp_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    mcst_dp #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (in_func),
        .i_timer_id  (in_id),
        .i_period    (in_period),
        .i_attach    (in_attach),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (out_kind),
        .o_out_id    (out_id),
        .o_out_run   (out_run),
        .o_out_ps    (out_ps),
        .o_out_pss   (out_pss),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {3'b000, out_pss, out_ps, out_run, out_id};

endmodule

// File: rtl/mcst_ctrl.sv
// Controller state machine of the soft timer bank.
`timescale 1ns / 1ps
module mcst_ctrl
    import mcst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_func   i_func,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   step_ok;

    assign step_ok = !(i_sts.fire_due && !i_sts.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_func == FUNC_TICK)) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (step_ok && i_sts.last_idx) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.walk_start = i_in_valid && (i_func == FUNC_TICK);
                o_cmd.cmd_exec   = i_in_valid && (i_func != FUNC_TICK);
            end
            ST_WALK: begin
                o_cmd.walk_step = step_ok;
            end
            ST_SUM: begin
                o_cmd.sum_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/mcst_dp.sv
// Datapath of the soft timer bank: counter memories, flags, tick state, result register.
`timescale 1ns / 1ps
module mcst_dp
    import mcst_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    input  t_func                i_func,
    input  logic [ID_W-1:0]      i_timer_id,
    input  logic [PERIOD_W-1:0]  i_period,
    input  logic                 i_attach,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_kind                o_out_kind,
    output logic [ID_W-1:0]      o_out_id,
    output logic [RUN_W-1:0]     o_out_run,
    output logic                 o_out_ps,
    output logic                 o_out_pss,
    output logic                 o_out_last
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IDX_XW = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam int CMP_W  = ID_W + 3;

    logic [COUNT_WIDTH-1:0] r_mem_rem [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_mem_rel [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] r_rd_rem;
    logic [COUNT_WIDTH-1:0] r_rd_rel;

    logic [NUM_TIMERS-1:0] r_valid, n_valid;
    logic [NUM_TIMERS-1:0] r_expired, n_expired;
    logic [NUM_TIMERS-1:0] r_auto, n_auto;
    logic [NUM_TIMERS-1:0] r_armed, n_armed;
    logic [IDX_W-1:0]      r_idx, n_idx;

    logic [DIV_W-1:0] r_slow_div, r_slower_div;
    logic [DIV_W-1:0] r_slow_phase, r_slower_phase;
    logic [RUN_W-1:0] r_tick;

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [ID_W-1:0]  r_out_id;
    logic [RUN_W-1:0] r_out_run;
    logic             r_out_ps, r_out_pss, r_out_last;

    logic [IDX_XW-1:0]      id_ext, idx_ext;
    logic [IDX_W-1:0]       cmd_idx;
    logic                   id_ok, start_ok, stop_ok;
    logic [COUNT_WIDTH-1:0] cur_rem, cur_rel, dec_rem, walk_rem;
    logic                   cur_nz, hit, new_exp, fire, last_idx;
    logic                   rd_en, wr_en;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   out_free;
    logic [RUN_W-1:0]       tick_inc, n_tick;
    logic [DIV_W-1:0]       slow_inc, slower_inc;
    logic                   ps, pss;

    // Command decode
    assign id_ext   = IDX_XW'(i_timer_id);
    assign cmd_idx  = id_ext[IDX_W-1:0];
    assign id_ok    = CMP_W'(i_timer_id) < CMP_W'(NUM_TIMERS);
    assign start_ok = i_cmd.cmd_exec && id_ok
                      && ((i_func == FUNC_START_ONE) || (i_func == FUNC_START_AUTO));
    assign stop_ok  = i_cmd.cmd_exec && id_ok && (i_func == FUNC_STOP);

    // Walk step on the timer at r_idx
    assign last_idx = (r_idx == IDX_W'(NUM_TIMERS - 1));
    assign cur_rem  = r_valid[r_idx] ? r_rd_rem : '0;
    assign cur_rel  = r_valid[r_idx] ? r_rd_rel : '0;
    assign cur_nz   = |cur_rem;
    assign dec_rem  = cur_rem - COUNT_WIDTH'(1);
    assign hit      = cur_nz && (dec_rem == '0);
    assign walk_rem = (hit && r_auto[r_idx]) ? cur_rel : dec_rem;
    assign new_exp  = r_expired[r_idx] || hit;
    assign fire     = new_exp && r_armed[r_idx];
    assign idx_ext  = IDX_XW'(r_idx);

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.last_idx = last_idx;
    assign o_sts.fire_due = fire;
    assign o_sts.out_free = out_free;

    // Memory ports
    assign rd_en   = i_cmd.walk_start || (i_cmd.walk_step && !last_idx);
    assign rd_addr = i_cmd.walk_start ? '0 : r_idx + IDX_W'(1);
    assign wr_en   = start_ok || (i_cmd.walk_step && cur_nz);
    assign wr_addr = i_cmd.cmd_exec ? cmd_idx : r_idx;
    assign wr_data = i_cmd.cmd_exec ? i_period[COUNT_WIDTH-1:0] : walk_rem;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_rem[wr_addr] <= wr_data;
        end
        if (start_ok) begin
            r_mem_rel[cmd_idx] <= i_period[COUNT_WIDTH-1:0];
        end
        if (rd_en) begin
            r_rd_rem <= r_mem_rem[rd_addr];
            r_rd_rel <= r_mem_rel[rd_addr];
        end
    end

    // Per-timer flags and walk index
    always_comb begin
        n_valid   = r_valid;
        n_expired = r_expired;
        n_auto    = r_auto;
        n_armed   = r_armed;
        n_idx     = r_idx;
        if (start_ok) begin
            n_valid[cmd_idx]   = 1'b1;
            n_expired[cmd_idx] = 1'b0;
            n_auto[cmd_idx]    = (i_func == FUNC_START_AUTO);
            n_armed[cmd_idx]   = i_attach;
        end
        if (stop_ok) begin
            n_armed[cmd_idx] = 1'b0;
        end
        if (i_cmd.walk_start) begin
            n_idx = '0;
        end
        if (i_cmd.walk_step) begin
            n_expired[r_idx] = new_exp && !fire;
            if (fire && !r_auto[r_idx]) begin
                n_armed[r_idx] = 1'b0;
            end
            if (!last_idx) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    // Run-time counter and divided pulses
    assign tick_inc   = r_tick + RUN_W'(1);
    assign n_tick     = (tick_inc == RUN_WRAP) ? '0 : tick_inc;
    assign slow_inc   = r_slow_phase + DIV_W'(1);
    assign slower_inc = r_slower_phase + DIV_W'(1);
    assign ps         = slow_inc >= r_slow_div;
    assign pss        = slower_inc >= r_slower_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_expired      <= '0;
            r_auto         <= '0;
            r_armed        <= '0;
            r_idx          <= '0;
            r_tick         <= '0;
            r_slow_phase   <= '0;
            r_slower_phase <= '0;
            r_slow_div     <= SLOW_DIV_RST;
            r_slower_div   <= SLOWER_DIV_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_expired <= n_expired;
            r_auto    <= n_auto;
            r_armed   <= n_armed;
            r_idx     <= n_idx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOW_DIV:   r_slow_div   <= i_cfg_wdata;
                    CFG_SLOWER_DIV: r_slower_div <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.sum_load) begin
                r_tick         <= n_tick;
                r_slow_phase   <= ps ? '0 : slow_inc;
                r_slower_phase <= pss ? '0 : slower_inc;
            end
            if ((i_cmd.walk_step && fire) || i_cmd.sum_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && fire) begin
            r_out_kind <= KIND_FIRED;
            r_out_id   <= idx_ext[ID_W-1:0];
            r_out_run  <= '0;
            r_out_ps   <= 1'b0;
            r_out_pss  <= 1'b0;
            r_out_last <= 1'b0;
        end else if (i_cmd.sum_load) begin
            r_out_kind <= KIND_SUMMARY;
            r_out_id   <= '0;
            r_out_run  <= n_tick;
            r_out_ps   <= ps;
            r_out_pss  <= pss;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_id    = r_out_id;
    assign o_out_run   = r_out_run;
    assign o_out_ps    = r_out_ps;
    assign o_out_pss   = r_out_pss;
    assign o_out_last  = r_out_last;

endmodule

// File: rtl/mcst_checker.sv
// Port-level checker of the soft timer bank and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcst_checker
    import mcst_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 m_axis_tlast
);

    logic tick_xfer;
    logic out_stall;
    logic last_ok;
    logic fired_out;
    logic fired_clean;

    assign tick_xfer   = s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == FUNC_TICK);
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign last_ok     = (m_axis_tlast == m_axis_tuser);
    assign fired_out   = m_axis_tvalid && (m_axis_tuser == KIND_FIRED);
    assign fired_clean = (m_axis_tdata[36:4] == '0);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid, "result dropped")
    `ASSERT_IMPL(a_last_kind, i_clk, i_rst_n, m_axis_tvalid, last_ok, "tlast and kind disagree")
    `ASSERT_IMPL(a_fired_zero, i_clk, i_rst_n, fired_out, fired_clean, "fired result not clean")
    `ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, tick_xfer, !s_axis_tready, "input taken in walk")

endmodule

bind multi_channel_soft_timer_bank mcst_checker u_mcst_checker (.*);
